[src/wheel30_prime_sieve_counter_assert.svh]
// Assertion macros used by the port-level checker of the wheel-30 sieve counter.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef WHEEL30_PRIME_SIEVE_COUNTER_ASSERT_SVH
`define WHEEL30_PRIME_SIEVE_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define W30_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sieve counter check failed");

// Next-cycle implication, disabled during reset.
`define W30_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sieve counter check failed");

`endif

[src/w30_pkg.sv]
// Types, constants and residue tables of the wheel-30 sieve counter.
// Depends on nothing.
`default_nettype none
package w30_pkg;

  localparam int WHEEL_SPAN   = 30;
  localparam int LIMIT_W      = 17;
  localparam int COUNT_W      = 14;
  localparam int CB_W         = 4;
  localparam int MV_W         = 18;
  localparam logic [LIMIT_W-1:0] MIN_LIMIT    = 17'd5;
  localparam logic [COUNT_W-1:0] EXTRA_PRIMES = 14'd3;

  typedef logic [7:0][4:0]  res_tbl_t;
  typedef logic [63:0][4:0] tbl5_t;
  typedef logic [63:0][2:0] tbl3_t;
  typedef logic [7:0][2:0]  sq3_t;

  localparam res_tbl_t RES = {5'd29, 5'd23, 5'd19, 5'd17, 5'd13, 5'd11, 5'd7, 5'd1};

  typedef struct packed {
    logic [LIMIT_W-1:0] limit;
    logic               err;
  } w30_job_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               err;
  } w30_res_t;

  function automatic int f_ridx(int v);
    int m;
    for (m = 0; m < 8; m++) begin
      if (int'(RES[m]) == v) return m;
    end
    return -1;
  endfunction

  // even step s from residue a for prime residue p; want 0 gives s, 1 the next index, 2 the carry
  function automatic int f_step(int a, int p, int want);
    int s;
    int m;
    for (s = 2; s < WHEEL_SPAN; s += 2) begin
      m = f_ridx((int'(RES[a]) + s * int'(RES[p])) % WHEEL_SPAN);
      if (m >= 0) begin
        if (want == 0) return s;
        if (want == 1) return m;
        return (int'(RES[a]) + s * int'(RES[p])) / WHEEL_SPAN;
      end
    end
    return (want == 0) ? 2 : 0;
  endfunction

  function automatic tbl5_t f_len_tbl();
    tbl5_t t;
    int a;
    int p;
    for (a = 0; a < 8; a++)
      for (p = 0; p < 8; p++) t[a*8+p] = 5'(f_step(a, p, 0));
    return t;
  endfunction

  function automatic tbl3_t f_next_tbl();
    tbl3_t t;
    int a;
    int p;
    for (a = 0; a < 8; a++)
      for (p = 0; p < 8; p++) t[a*8+p] = 3'(f_step(a, p, 1));
    return t;
  endfunction

  function automatic tbl5_t f_carry_tbl();
    tbl5_t t;
    int a;
    int p;
    for (a = 0; a < 8; a++)
      for (p = 0; p < 8; p++) t[a*8+p] = 5'(f_step(a, p, 2));
    return t;
  endfunction

  function automatic sq3_t f_sqidx_tbl();
    sq3_t t;
    int p;
    int m;
    for (p = 0; p < 8; p++) begin
      m = f_ridx((int'(RES[p]) * int'(RES[p])) % WHEEL_SPAN);
      t[p] = (m >= 0) ? 3'(m) : 3'd0;
    end
    return t;
  endfunction

  function automatic res_tbl_t f_sqdiv_tbl();
    res_tbl_t t;
    int p;
    for (p = 0; p < 8; p++) t[p] = 5'((int'(RES[p]) * int'(RES[p])) / WHEEL_SPAN);
    return t;
  endfunction

  localparam tbl5_t    STEP_LEN  = f_len_tbl();
  localparam tbl3_t    STEP_NEXT = f_next_tbl();
  localparam tbl5_t    STEP_CARRY = f_carry_tbl();
  localparam sq3_t     SQ_IDX    = f_sqidx_tbl();
  localparam res_tbl_t SQ_DIV    = f_sqdiv_tbl();

endpackage
`default_nettype wire

[src/wheel30_prime_sieve_counter.sv]
// Flow: a flagged limit goes straight to the result; a valid limit clears all WHEEL_BYTES
// bitmap bytes, takes the integer root, sieves each candidate byte and residue (each marked
// multiple takes one RAM read and one write) and then counts the bitmap bytes.
// Throughput: one request at a time in the sieve engine; a two-entry job queue and the
// output register let new limits be taken while a result waits.
// Reset: synchronous active-low rst_n empties queue, engine and output register.
`default_nettype none
module wheel30_prime_sieve_counter #(
  parameter int WHEEL_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [16:0] in_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [13:0]      out_prime_count,
  output logic             out_limit_error
);
  import w30_pkg::*;

  logic     job_valid, job_ready;
  w30_job_t job;
  logic     res_valid, res_ready;
  w30_res_t res;

  logic     out_valid_r;
  w30_res_t out_r;

  // front: classify and queue each transfer
  w30_front #(.WHEEL_BYTES(WHEEL_BYTES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_limit  (in_limit),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  // back: sieve and count in the bitmap RAM
  w30_engine #(.WHEEL_BYTES(WHEEL_BYTES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register: load when empty or when its result transfers this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) out_r <= res;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_count = out_r.count;
  assign out_limit_error = out_r.err;
endmodule
`default_nettype wire

[src/w30_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module w30_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/w30_front.sv]
// Front end: accepts limits, flags out-of-range ones, queues jobs (two entries).
// Depends on w30_pkg.
`default_nettype none
module w30_front #(
  parameter int WHEEL_BYTES = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [16:0]              in_limit,
  output logic                          job_valid,
  input  wire logic                     job_ready,
  output w30_pkg::w30_job_t             job
);
  import w30_pkg::*;

  localparam logic [21:0] MAX_LIMIT = 22'(WHEEL_SPAN * WHEEL_BYTES - 1);

  w30_job_t   q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  w30_job_t   new_job;
  logic       push, pop;

  always_comb begin
    new_job.limit = in_limit;
    new_job.err   = (in_limit < MIN_LIMIT) || ({5'b0, in_limit} > MAX_LIMIT);
  end

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= new_job;
  end
endmodule
`default_nettype wire

[src/w30_engine.sv]
// Back end: clears the wheel bitmap, takes the root, sieves and counts.
// Depends on w30_pkg and w30_ram.
`default_nettype none
module w30_engine #(
  parameter int WHEEL_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          job_valid,
  output logic               job_ready,
  input  wire w30_pkg::w30_job_t job,
  output logic               res_valid,
  input  wire logic          res_ready,
  output w30_pkg::w30_res_t  res
);
  import w30_pkg::*;

  localparam int AW = (WHEEL_BYTES > 1) ? $clog2(WHEEL_BYTES) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WHEEL_BYTES - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_SQRT   = 4'd2;
  localparam logic [3:0] S_CRD    = 4'd3;
  localparam logic [3:0] S_CLATCH = 4'd4;
  localparam logic [3:0] S_CJ     = 4'd5;
  localparam logic [3:0] S_INIT1  = 4'd6;
  localparam logic [3:0] S_INIT2  = 4'd7;
  localparam logic [3:0] S_MCHK   = 4'd8;
  localparam logic [3:0] S_MRD    = 4'd9;
  localparam logic [3:0] S_MWR    = 4'd10;
  localparam logic [3:0] S_KRD    = 4'd11;
  localparam logic [3:0] S_KACC   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]         state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r, limit_nxt;
  logic               err_r, err_nxt;
  logic [8:0]         root_r, root_nxt;
  logic [3:0]         sq_i_r, sq_i_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CB_W-1:0]    cb_r, cb_nxt;
  logic [8:0]         base_r, base_nxt;
  logic [2:0]         j_r, j_nxt;
  logic [7:0]         cdata_r, cdata_nxt;
  logic [8:0]         p_r, p_nxt;
  logic [7:0]         bsq_r, bsq_nxt;
  logic [MV_W-1:0]    m_r, m_nxt;
  logic [MV_W-1:0]    mb_r, mb_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [AW-1:0]      kb_r, kb_nxt;
  logic [MV_W-1:0]    kbase_r, kbase_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [7:0]         wdata, rdata;

  logic [8:0]         trial;
  logic [17:0]        trial_sq;
  logic [5:0]         tidx;
  logic [4:0]         s_len;
  logic [13:0]        sp;
  logic [MV_W-1:0]    step_m;
  logic [MV_W-1:0]    lim_ext;
  logic [7:0]         kmask;
  logic [3:0]         kpop;

  w30_ram #(.WIDTH(8), .DEPTH(WHEEL_BYTES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign lim_ext  = {1'b0, limit_r};
  assign trial    = root_r | (9'd1 << sq_i_r);
  assign trial_sq = 18'(trial) * 18'(trial);
  assign tidx     = {k_r, j_r};
  assign s_len    = STEP_LEN[tidx];
  assign sp       = 14'(s_len) * 14'(p_r);
  assign step_m   = m_r + 18'(sp);

  always_comb begin
    kmask = '0;
    kpop  = '0;
    for (int jj = 0; jj < 8; jj++) begin
      kmask[jj] = !rdata[jj] && ((kbase_r + 18'(RES[jj])) <= lim_ext);
      kpop      = kpop + 4'(kmask[jj]);
    end
  end

  assign res_valid = (state_r == S_DONE);
  assign res.count = cnt_r;
  assign res.err   = err_r;

  always_comb begin
    logic adv;
    state_nxt = state_r;
    limit_nxt = limit_r;
    err_nxt   = err_r;
    root_nxt  = root_r;
    sq_i_nxt  = sq_i_r;
    clr_nxt   = clr_r;
    cb_nxt    = cb_r;
    base_nxt  = base_r;
    j_nxt     = j_r;
    cdata_nxt = cdata_r;
    p_nxt     = p_r;
    bsq_nxt   = bsq_r;
    m_nxt     = m_r;
    mb_nxt    = mb_r;
    k_nxt     = k_r;
    kb_nxt    = kb_r;
    kbase_nxt = kbase_r;
    cnt_nxt   = cnt_r;
    job_ready = 1'b0;
    we        = 1'b0;
    waddr     = clr_r;
    wdata     = 8'd0;
    raddr     = AW'(cb_r);
    adv       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_ready = 1'b1;
          limit_nxt = job.limit;
          err_nxt   = job.err;
          clr_nxt   = '0;
          if (job.err) begin
            cnt_nxt   = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        // byte 0 holds the value 1, which is not prime
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = (clr_r == '0) ? 8'd1 : 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_ADDR) begin
          root_nxt  = '0;
          sq_i_nxt  = 4'd8;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (trial_sq <= lim_ext) root_nxt = trial;
        sq_i_nxt = sq_i_r - 1'b1;
        if (sq_i_r == 4'd0) begin
          cb_nxt    = '0;
          base_nxt  = '0;
          state_nxt = S_CRD;
        end
      end
      S_CRD: begin
        raddr     = AW'(cb_r);
        state_nxt = S_CLATCH;
      end
      S_CLATCH: begin
        cdata_nxt = rdata;
        j_nxt     = '0;
        state_nxt = S_CJ;
      end
      S_CJ: begin
        if (cdata_r[j_r]) adv = 1'b1;
        else state_nxt = S_INIT1;
      end
      S_INIT1: begin
        bsq_nxt   = 8'(cb_r) * 8'(cb_r);
        p_nxt     = base_r + 9'(RES[j_r]);
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        m_nxt     = 18'(p_r) * 18'(p_r);
        mb_nxt    = 18'(bsq_r) * 18'd30 + 18'(cb_r) * 18'(RES[j_r]) * 18'd2
                    + 18'(SQ_DIV[j_r]);
        k_nxt     = SQ_IDX[j_r];
        state_nxt = S_MCHK;
      end
      S_MCHK: begin
        if (m_r <= lim_ext) state_nxt = S_MRD;
        else adv = 1'b1;
      end
      S_MRD: begin
        raddr     = mb_r[AW-1:0];
        state_nxt = S_MWR;
      end
      S_MWR: begin
        we     = 1'b1;
        waddr  = mb_r[AW-1:0];
        wdata  = rdata | (8'd1 << k_r);
        m_nxt  = step_m;
        mb_nxt = mb_r + 18'(s_len * 9'(cb_r)) + 18'(STEP_CARRY[tidx]);
        k_nxt  = STEP_NEXT[tidx];
        if (step_m <= lim_ext) state_nxt = S_MRD;
        else adv = 1'b1;
      end
      S_KRD: begin
        raddr     = kb_r;
        state_nxt = S_KACC;
      end
      S_KACC: begin
        cnt_nxt   = cnt_r + COUNT_W'(kpop);
        kb_nxt    = kb_r + 1'b1;
        kbase_nxt = kbase_r + 18'd30;
        if ((kbase_r + 18'd30) > lim_ext) state_nxt = S_DONE;
        else state_nxt = S_KRD;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // move to the next candidate residue, or to the next candidate byte
    if (adv) begin
      if (j_r == 3'd7) begin
        cb_nxt   = cb_r + 1'b1;
        base_nxt = base_r + 9'd30;
        if ((base_r + 9'd30) > root_r) begin
          kb_nxt    = '0;
          kbase_nxt = '0;
          cnt_nxt   = EXTRA_PRIMES;
          state_nxt = S_KRD;
        end else begin
          state_nxt = S_CRD;
        end
      end else begin
        j_nxt     = j_r + 1'b1;
        state_nxt = S_CJ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    limit_r <= limit_nxt;
    err_r   <= err_nxt;
    root_r  <= root_nxt;
    sq_i_r  <= sq_i_nxt;
    clr_r   <= clr_nxt;
    cb_r    <= cb_nxt;
    base_r  <= base_nxt;
    j_r     <= j_nxt;
    cdata_r <= cdata_nxt;
    p_r     <= p_nxt;
    bsq_r   <= bsq_nxt;
    m_r     <= m_nxt;
    mb_r    <= mb_nxt;
    k_r     <= k_nxt;
    kb_r    <= kb_nxt;
    kbase_r <= kbase_nxt;
    cnt_r   <= cnt_nxt;
  end
endmodule
`default_nettype wire

[src/w30_chk.sv]
// Port-level checker for the wheel-30 sieve counter, bound to the top level.
// Depends on wheel30_prime_sieve_counter_assert.svh.
`default_nettype none
`include "wheel30_prime_sieve_counter_assert.svh"
module w30_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [13:0] out_prime_count,
  input wire logic        out_limit_error
);
  // a stalled result holds
  `W30_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_prime_count) && $stable(out_limit_error))
  // a flagged limit reports zero primes
  `W30_ASSERT_IMPL(a_err_zero, out_valid && out_limit_error, out_prime_count == 14'd0)
  // any accepted limit covers 2, 3 and 5
  `W30_ASSERT_IMPL(a_min_count, out_valid && !out_limit_error, out_prime_count >= 14'd3)
endmodule

bind wheel30_prime_sieve_counter w30_chk u_chk (.*);
`default_nettype wire
